FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module tcc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants for the tetrahedron circumcenter pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COORD_BITS          = 16;
  localparam int EXTRA_FRACTION_BITS = 8;
  localparam int VOL_BITS            = 54;
  localparam int CENTER_BITS         = 32;
  // Quotients at or above 2**QCAP_BIT always clamp, so they are capped there.
  localparam int QCAP_BIT            = 37;

endpackage

FILE: hw/rtl/tcc_div_pipe.sv
// ----------------------------------------------------------------------------
// tcc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tcc_div_pipe #(
  parameter int DIVW   = 79,
  parameter int DVW    = 55,
  parameter int SIDE_W = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DIVW-1:0]   dividend,
  input  logic [DVW-1:0]    divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic [DIVW-1:0]   quotient,
  output logic [DVW-1:0]    remainder,
  output logic [DVW-1:0]    divisor_out,
  output logic [SIDE_W-1:0] side_out
);

  // Each stage holds the partial remainder and one word that shifts out
  // dividend bits at the top and takes quotient bits at the bottom.
  logic [DVW-1:0]    rem_r  [0:DIVW-1];
  logic [DIVW-1:0]   nq_r   [0:DIVW-1];
  logic [DVW-1:0]    dv_r   [0:DIVW-1];
  logic [SIDE_W-1:0] side_r [0:DIVW-1];

  genvar i;
  for (i = 0; i < DIVW; i++) begin : g_stage
    logic [DVW-1:0]    rem_in;
    logic [DVW-1:0]    dv_in;
    logic [DIVW-1:0]   nq_in;
    logic [SIDE_W-1:0] side_cur;
    logic [DVW:0]      trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in   = '0;
      assign dv_in    = divisor;
      assign nq_in    = dividend;
      assign side_cur = side_in;
    end else begin : g_rest
      assign rem_in   = rem_r[i-1];
      assign dv_in    = dv_r[i-1];
      assign nq_in    = nq_r[i-1];
      assign side_cur = side_r[i-1];
    end

    assign trial = {rem_in, nq_in[DIVW-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DVW'(trial - {1'b0, dv_in}) : trial[DVW-1:0];
        nq_r[i]   <= {nq_in[DIVW-2:0], ge};
        dv_r[i]   <= dv_in;
        side_r[i] <= side_cur;
      end
    end
  end

  assign quotient    = nq_r[DIVW-1];
  assign remainder   = rem_r[DIVW-1];
  assign divisor_out = dv_r[DIVW-1];
  assign side_out    = side_r[DIVW-1];

endmodule

FILE: hw/rtl/tetra_circumcenter_core.sv
// Divider width: DIVW = 4*COORD_BITS + 7 + EXTRA_FRACTION_BITS (79 by default).
// Throughput: one item per cycle while the output is not stalled; six arithmetic
// stages, a divider with one quotient bit per stage, a rounding stage and the output register.
// A stall on a valid output freezes the whole pipeline; bubbles pass through.
// Reset (rst, synchronous) clears the valid bits only; data registers keep contents.
// ----------------------------------------------------------------------------
// tetra_circumcenter_core
// Six-fold volume and circumsphere center of a tetrahedron, fixed point.
// ----------------------------------------------------------------------------
module tetra_circumcenter_core #(
  parameter int COORD_BITS          = tcc_pkg::COORD_BITS,
  parameter int EXTRA_FRACTION_BITS = tcc_pkg::EXTRA_FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          vertex0_x,
  input  logic signed [COORD_BITS-1:0]          vertex0_y,
  input  logic signed [COORD_BITS-1:0]          vertex0_z,
  input  logic signed [COORD_BITS-1:0]          vertex1_x,
  input  logic signed [COORD_BITS-1:0]          vertex1_y,
  input  logic signed [COORD_BITS-1:0]          vertex1_z,
  input  logic signed [COORD_BITS-1:0]          vertex2_x,
  input  logic signed [COORD_BITS-1:0]          vertex2_y,
  input  logic signed [COORD_BITS-1:0]          vertex2_z,
  input  logic signed [COORD_BITS-1:0]          vertex3_x,
  input  logic signed [COORD_BITS-1:0]          vertex3_y,
  input  logic signed [COORD_BITS-1:0]          vertex3_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tcc_pkg::VOL_BITS-1:0]    six_volume,
  output logic signed [tcc_pkg::CENTER_BITS-1:0] center_x,
  output logic signed [tcc_pkg::CENTER_BITS-1:0] center_y,
  output logic signed [tcc_pkg::CENTER_BITS-1:0] center_z,
  output logic                                  degenerate,
  output logic                                  clipped
);

  localparam int CB    = COORD_BITS;
  localparam int EF    = EXTRA_FRACTION_BITS;
  localparam int DW    = CB + 1;          // edge component
  localparam int CW    = 2 * CB + 3;      // cross product component
  localparam int SW    = 2 * CB + 2;      // squared edge length, unsigned
  localparam int SL    = SW / 2;
  localparam int SH    = SW - SL;
  localparam int PLW   = CW + SL + 1;
  localparam int PHW   = CW + SH + 1;
  localparam int TW    = SW + CW;         // one numerator term
  localparam int NW    = TW + 2;          // numerator
  localparam int DETW  = DW + CW + 2;     // determinant
  localparam int DIVW  = NW + EF;
  localparam int DVW   = DETW + 1;
  localparam int QC    = tcc_pkg::QCAP_BIT;
  localparam int TOTW  = QC + 3;
  localparam int OUTW  = tcc_pkg::CENTER_BITS;
  localparam int LAT   = 8 + DIVW;
  localparam int S0W   = DETW + CB + 2;
  localparam int S1W   = CB + 1;

  localparam int NXT [0:2] = '{1, 2, 0};
  localparam int PRV [0:2] = '{2, 0, 1};
  // cross 0 = d2 x d3, cross 1 = d3 x d1, cross 2 = d1 x d2
  localparam int UI  [0:2] = '{2, 3, 1};
  localparam int VI  [0:2] = '{3, 1, 2};

  localparam logic signed [TOTW-1:0] CMAX = {{(TOTW-OUTW+1){1'b0}}, {(OUTW-1){1'b1}}};
  localparam logic signed [TOTW-1:0] CMIN = ~CMAX;

  logic           en;
  logic [LAT-1:0] vpipe;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  logic signed [CB-1:0] vin [0:3][0:2];
  assign vin[0] = '{vertex0_x, vertex0_y, vertex0_z};
  assign vin[1] = '{vertex1_x, vertex1_y, vertex1_z};
  assign vin[2] = '{vertex2_x, vertex2_y, vertex2_z};
  assign vin[3] = '{vertex3_x, vertex3_y, vertex3_z};

  // Stage A: edges from vertex 0
  logic signed [DW-1:0] a_d [1:3][0:2];
  logic signed [CB-1:0] a_p0 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          a_d[j][k] <= DW'(vin[j][k]) - DW'(vin[0][k]);
        end
      end
      a_p0 <= vin[0];
    end
  end

  // Stage B: cross products and squared lengths
  logic signed [2*DW-1:0] pa [0:2][0:2];
  logic signed [2*DW-1:0] pb [0:2][0:2];
  logic signed [2*DW-1:0] sq [0:2][0:2];
  logic signed [CW-1:0]   b_c_next [0:2][0:2];
  logic [SW-1:0]          b_s_next [0:2];
  logic signed [CW-1:0]   b_c [0:2][0:2];
  logic [SW-1:0]          b_s [0:2];
  logic signed [DW-1:0]   b_d1 [0:2];
  logic signed [CB-1:0]   b_p0 [0:2];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int k = 0; k < 3; k++) begin
        pa[x][k] = a_d[UI[x]][NXT[k]] * a_d[VI[x]][PRV[k]];
        pb[x][k] = a_d[UI[x]][PRV[k]] * a_d[VI[x]][NXT[k]];
        b_c_next[x][k] = CW'(pa[x][k]) - CW'(pb[x][k]);
        sq[x][k] = a_d[x+1][k] * a_d[x+1][k];
      end
      b_s_next[x] = sq[x][0][SW-1:0] + sq[x][1][SW-1:0] + sq[x][2][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_c  <= b_c_next;
      b_s  <= b_s_next;
      b_d1 <= a_d[1];
      b_p0 <= a_p0;
    end
  end

  // Stage C: partial products for the determinant and the numerators
  logic signed [DW+CW-1:0] c_pdet_next [0:2];
  logic signed [PLW-1:0]   c_pl_next [0:2][0:2];
  logic signed [PHW-1:0]   c_ph_next [0:2][0:2];
  logic signed [DW+CW-1:0] c_pdet [0:2];
  logic signed [PLW-1:0]   c_pl [0:2][0:2];
  logic signed [PHW-1:0]   c_ph [0:2][0:2];
  logic signed [CB-1:0]    c_p0 [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_pdet_next[k] = b_d1[k] * b_c[0][k];
      for (int j = 0; j < 3; j++) begin
        c_pl_next[k][j] = $signed({1'b0, b_s[j][SL-1:0]}) * b_c[j][k];
        c_ph_next[k][j] = $signed({1'b0, b_s[j][SW-1:SL]}) * b_c[j][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pdet <= c_pdet_next;
      c_pl   <= c_pl_next;
      c_ph   <= c_ph_next;
      c_p0   <= b_p0;
    end
  end

  // Stage D: determinant and numerator terms
  logic signed [DETW-1:0] d_det;
  logic signed [TW-1:0]   d_t [0:2][0:2];
  logic signed [CB-1:0]   d_p0 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      d_det <= DETW'(c_pdet[0]) + DETW'(c_pdet[1]) + DETW'(c_pdet[2]);
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          d_t[k][j] <= (TW'(c_ph[k][j]) <<< SL) + TW'(c_pl[k][j]);
        end
      end
      d_p0 <= c_p0;
    end
  end

  // Stage E: numerators
  logic signed [DETW-1:0] e_det;
  logic signed [NW-1:0]   e_n [0:2];
  logic signed [CB-1:0]   e_p0 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      e_det <= d_det;
      for (int k = 0; k < 3; k++) begin
        e_n[k] <= NW'(d_t[k][0]) + NW'(d_t[k][1]) + NW'(d_t[k][2]);
      end
      e_p0 <= d_p0;
    end
  end

  // Stage F: magnitudes and signs for the divider
  logic [NW-1:0]          nmag [0:2];
  logic [DETW-1:0]        detmag;
  logic [DIVW-1:0]        f_dividend [0:2];
  logic [DVW-1:0]         f_divisor;
  logic                   f_neg [0:2];
  logic signed [CB-1:0]   f_p0 [0:2];
  logic signed [DETW-1:0] f_det;
  logic                   f_degen;

  always_comb begin
    detmag = e_det[DETW-1] ? DETW'(-e_det) : DETW'(e_det);
    for (int k = 0; k < 3; k++) begin
      nmag[k] = e_n[k][NW-1] ? NW'(-e_n[k]) : NW'(e_n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f_dividend[k] <= DIVW'(nmag[k]) << EF;
        f_neg[k]      <= e_n[k][NW-1] ^ e_det[DETW-1];
      end
      f_divisor <= {detmag, 1'b0};
      f_p0      <= e_p0;
      f_det     <= e_det;
      f_degen   <= (e_det == '0);
    end
  end

  // Divider lanes
  logic [DIVW-1:0]      q_l   [0:2];
  logic [DVW-1:0]       rem_l [0:2];
  logic [DVW-1:0]       dv_l  [0:2];
  logic [S0W-1:0]       side0;
  logic [S1W-1:0]       side1;
  logic [S1W-1:0]       side2;
  logic                 neg_l  [0:2];
  logic signed [CB-1:0] base_l [0:2];
  logic signed [DETW-1:0] l_det;
  logic                 l_degen;

  tcc_div_pipe #(.DIVW(DIVW), .DVW(DVW), .SIDE_W(S0W)) u_div_x (
    .clk         (clk),
    .en          (en),
    .dividend    (f_dividend[0]),
    .divisor     (f_divisor),
    .side_in     ({f_degen, f_det, f_neg[0], f_p0[0]}),
    .quotient    (q_l[0]),
    .remainder   (rem_l[0]),
    .divisor_out (dv_l[0]),
    .side_out    (side0)
  );

  tcc_div_pipe #(.DIVW(DIVW), .DVW(DVW), .SIDE_W(S1W)) u_div_y (
    .clk         (clk),
    .en          (en),
    .dividend    (f_dividend[1]),
    .divisor     (f_divisor),
    .side_in     ({f_neg[1], f_p0[1]}),
    .quotient    (q_l[1]),
    .remainder   (rem_l[1]),
    .divisor_out (dv_l[1]),
    .side_out    (side1)
  );

  tcc_div_pipe #(.DIVW(DIVW), .DVW(DVW), .SIDE_W(S1W)) u_div_z (
    .clk         (clk),
    .en          (en),
    .dividend    (f_dividend[2]),
    .divisor     (f_divisor),
    .side_in     ({f_neg[2], f_p0[2]}),
    .quotient    (q_l[2]),
    .remainder   (rem_l[2]),
    .divisor_out (dv_l[2]),
    .side_out    (side2)
  );

  assign {l_degen, l_det, neg_l[0], base_l[0]} = side0;
  assign {neg_l[1], base_l[1]} = side1;
  assign {neg_l[2], base_l[2]} = side2;

  // Stage R1: round half away from zero, cap large quotients
  logic [DIVW:0]          qr [0:2];
  logic [QC:0]            g_qs [0:2];
  logic                   g_neg [0:2];
  logic signed [CB-1:0]   g_base [0:2];
  logic signed [DETW-1:0] g_det;
  logic                   g_degen;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qr[k] = (DIVW+1)'(q_l[k]) +
              (DIVW+1)'({rem_l[k], 1'b0} >= {1'b0, dv_l[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g_qs[k]   <= (|qr[k][DIVW:QC]) ? (QC+1)'(1) << QC : qr[k][QC:0];
        g_neg[k]  <= neg_l[k];
        g_base[k] <= base_l[k];
      end
      g_det   <= l_det;
      g_degen <= l_degen;
    end
  end

  // Stage R2: add the base coordinate, clamp (zero when degenerate), output register
  logic signed [TOTW-1:0] off [0:2];
  logic signed [TOTW-1:0] tot [0:2];
  logic signed [OUTW-1:0] cen [0:2];
  logic [2:0]             clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k] = g_neg[k] ? -$signed(TOTW'(g_qs[k])) : $signed(TOTW'(g_qs[k]));
      tot[k] = off[k] + (TOTW'(g_base[k]) <<< EF);
      clip[k] = 1'b0;
      if (g_degen) begin
        cen[k] = '0;
      end else if (tot[k] > CMAX) begin
        cen[k]  = CMAX[OUTW-1:0];
        clip[k] = 1'b1;
      end else if (tot[k] < CMIN) begin
        cen[k]  = CMIN[OUTW-1:0];
        clip[k] = 1'b1;
      end else begin
        cen[k] = tot[k][OUTW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      six_volume <= tcc_pkg::VOL_BITS'(g_det);
      center_x   <= cen[0];
      center_y   <= cen[1];
      center_z   <= cen[2];
      degenerate <= g_degen;
      clipped    <= |clip;
    end
  end

endmodule

FILE: hw/rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for tetra_circumcenter_core, bound to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [tcc_pkg::VOL_BITS-1:0]    six_volume,
  input logic signed [tcc_pkg::CENTER_BITS-1:0] center_x,
  input logic signed [tcc_pkg::CENTER_BITS-1:0] center_y,
  input logic signed [tcc_pkg::CENTER_BITS-1:0] center_z,
  input logic                                  degenerate,
  input logic                                  clipped
);

  localparam int OUTW = tcc_pkg::CENTER_BITS;
  localparam logic signed [OUTW-1:0] CMAX = {1'b0, {(OUTW-1){1'b1}}};
  localparam logic signed [OUTW-1:0] CMIN = ~CMAX;

  `TCC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `TCC_ASSERT_NOW(a_backpressure, clk, rst, out_valid && out_stall, in_stall)
  `TCC_ASSERT_NOW(a_degen_zero, clk, rst, out_valid && degenerate, six_volume == 0 && center_x == 0 && center_y == 0 && center_z == 0 && !clipped)
  `TCC_ASSERT_NOW(a_clip_rail, clk, rst, out_valid && clipped, center_x == CMAX || center_x == CMIN || center_y == CMAX || center_y == CMIN || center_z == CMAX || center_z == CMIN)

endmodule

bind tetra_circumcenter_core tcc_checker u_tcc_checker (.*);

FILE: tb/sv/tetra_circumcenter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tetra_circumcenter_core_test
// Streams tetrahedra through the core under random idling on both sides and
// checks each result against a predictor of volume and circumcenter.
// ----------------------------------------------------------------------------
module tetra_circumcenter_core_test;

  localparam int CB = tcc_pkg::COORD_BITS;
  localparam int XF = tcc_pkg::EXTRA_FRACTION_BITS;
  localparam int LAT = 8 + 4 * CB + 7 + XF;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CB-1:0] crd [12];
    bit                   hold_for_drain;
  } tetra_t;

  typedef struct {
    logic signed [tcc_pkg::VOL_BITS-1:0]    vol;
    logic signed [tcc_pkg::CENTER_BITS-1:0] cx, cy, cz;
    logic                                   degen, clip;
  } sphere_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [CB-1:0] crd [12] = '{default: '0};
  logic signed [tcc_pkg::VOL_BITS-1:0]    six_volume;
  logic signed [tcc_pkg::CENTER_BITS-1:0] center_x, center_y, center_z;
  logic degenerate, clipped;

  tetra_t  pending_q [$];
  sphere_t expected_q [$];
  int      fail_cnt = 0;
  int      cyc = 0;
  int      accepted = 0;
  int      hold_left = 0;
  bit      hold_done = 0;
  bit      in_taken = 0;

  always #4 clk = ~clk;

  tetra_circumcenter_core i_dut (
    .clk, .rst, .in_valid, .in_stall,
    .vertex0_x(crd[0]), .vertex0_y(crd[1]), .vertex0_z(crd[2]),
    .vertex1_x(crd[3]), .vertex1_y(crd[4]), .vertex1_z(crd[5]),
    .vertex2_x(crd[6]), .vertex2_y(crd[7]), .vertex2_z(crd[8]),
    .vertex3_x(crd[9]), .vertex3_y(crd[10]), .vertex3_z(crd[11]),
    .out_valid, .out_stall, .six_volume, .center_x, .center_y, .center_z,
    .degenerate, .clipped
  );

  // Offset N * 2^XF / (2 det), rounded half away from zero, plus base, saturated.
  function automatic logic signed [31:0] round_center(longint base, wide_t num,
                                                      longint det, inout bit clip);
    logic [127:0] mag, dv, q, r;
    longint       tot;
    bit           neg;
    neg = (num < 0) != (det < 0);
    mag = (num < 0) ? -num : num;
    mag = mag << XF;
    dv  = 128'(det < 0 ? -det : det) << 1;
    q   = mag / dv;
    r   = mag % dv;
    if (2 * r >= dv) q = q + 1;
    if (q > (128'd1 << 62)) begin
      clip = 1;
      return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    tot = (neg ? -longint'(q[63:0]) : longint'(q[63:0])) + base * (64'sd1 << XF);
    if (tot > 64'sd2147483647) begin
      clip = 1;
      return 32'sh7fff_ffff;
    end
    if (tot < -64'sd2147483648) begin
      clip = 1;
      return 32'sh8000_0000;
    end
    return tot[31:0];
  endfunction

  function automatic sphere_t predict_sphere(tetra_t t);
    longint  p0 [3], d1 [3], d2 [3], d3 [3], c23 [3], c31 [3], c12 [3];
    longint  s1, s2, s3, det;
    wide_t   num;
    bit      clip;
    sphere_t res;
    logic signed [31:0] cc [3];
    clip = 0;
    for (int k = 0; k < 3; k++) begin
      p0[k] = t.crd[k];
      d1[k] = longint'(t.crd[3 + k]) - p0[k];
      d2[k] = longint'(t.crd[6 + k]) - p0[k];
      d3[k] = longint'(t.crd[9 + k]) - p0[k];
    end
    det = d1[0]*d2[1]*d3[2] + d1[1]*d2[2]*d3[0] + d1[2]*d2[0]*d3[1]
        - d1[0]*d2[2]*d3[1] - d1[1]*d2[0]*d3[2] - d1[2]*d2[1]*d3[0];
    res.vol = det[53:0];
    res.cx = '0; res.cy = '0; res.cz = '0;
    res.degen = (det == 0);
    res.clip = 0;
    if (det == 0) return res;
    for (int k = 0; k < 3; k++) begin
      c23[k] = d2[(k+1)%3]*d3[(k+2)%3] - d2[(k+2)%3]*d3[(k+1)%3];
      c31[k] = d3[(k+1)%3]*d1[(k+2)%3] - d3[(k+2)%3]*d1[(k+1)%3];
      c12[k] = d1[(k+1)%3]*d2[(k+2)%3] - d1[(k+2)%3]*d2[(k+1)%3];
    end
    s1 = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    s2 = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    s3 = d3[0]*d3[0] + d3[1]*d3[1] + d3[2]*d3[2];
    for (int k = 0; k < 3; k++) begin
      num = wide_t'(s1) * wide_t'(c23[k]) + wide_t'(s2) * wide_t'(c31[k])
          + wide_t'(s3) * wide_t'(c12[k]);
      cc[k] = round_center(p0[k], num, det, clip);
    end
    res.cx = cc[0]; res.cy = cc[1]; res.cz = cc[2];
    res.clip = clip;
    return res;
  endfunction

  // Directed items: vertices given as 12 raw coordinates.
  function automatic tetra_t make_tetra(int v [12]);
    tetra_t t;
    for (int i = 0; i < 12; i++) t.crd[i] = CB'(v[i]);
    t.hold_for_drain = 0;
    return t;
  endfunction

  function automatic tetra_t random_tetra();
    tetra_t t;
    int     span, mode;
    mode = $urandom_range(99);
    span = (mode < 40) ? 65535 : (mode < 75) ? 2047 : 255;
    t.hold_for_drain = 0;
    for (int i = 0; i < 12; i++)
      if (span == 65535) t.crd[i] = CB'($urandom);
      else t.crd[i] = CB'($urandom_range(span) - span / 2);
    // coplanar and repeated vertices give a zero determinant
    if (mode >= 90) for (int i = 0; i < 3; i++) t.crd[9 + i] = t.crd[$urandom_range(2) * 3 + i];
    return t;
  endfunction

  // Sender: advance on acceptance, wait for a drain at the marker item, idle at random outside a quiet stretch.
  always @(negedge clk) begin
    tetra_t nxt;
    bit     drive;
    cyc <= cyc + 1;
    if (!rst && (!in_valid || in_taken)) begin
      drive = 0;
      if (pending_q.size() > 0 && pending_q[0].hold_for_drain && expected_q.size() == 0)
        void'(pending_q.pop_front());
      if (pending_q.size() > 0 && !pending_q[0].hold_for_drain &&
          !((cyc < 800 || cyc > 1000) && $urandom_range(99) < 12)) begin
        nxt = pending_q.pop_front();
        crd <= nxt.crd;
        drive = 1;
      end
      in_valid <= drive;
    end
  end

  // Receiver: one long hold-off once over 200 items are accepted, random stalls outside a quiet stretch.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else if (!hold_done && accepted > 200) begin
      hold_done <= 1;
      hold_left <= 300;
      out_stall <= 1;
    end else begin
      out_stall <= (cyc > 800 && cyc < 1000) ? 1'b0 : ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    sphere_t e;
    tetra_t  t;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      t.crd = crd;
      t.hold_for_drain = 0;
      expected_q.push_back(predict_sphere(t));
      accepted <= accepted + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (six_volume !== e.vol) begin
          $error("six_volume exp %0d got %0d", e.vol, six_volume); fail_cnt++;
        end
        if (center_x !== e.cx) begin
          $error("center_x exp %0d got %0d", e.cx, center_x); fail_cnt++;
        end
        if (center_y !== e.cy) begin
          $error("center_y exp %0d got %0d", e.cy, center_y); fail_cnt++;
        end
        if (center_z !== e.cz) begin
          $error("center_z exp %0d got %0d", e.cz, center_z); fail_cnt++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate); fail_cnt++;
        end
        if (clipped !== e.clip) begin
          $error("clipped exp %0d got %0d", e.clip, clipped); fail_cnt++;
        end
      end
    end
  end

  initial begin
    tetra_t t;
    pending_q.push_back(make_tetra('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
    pending_q.push_back(make_tetra('{0,0,0, 256,0,0, 0,256,0, 0,0,256}));
    pending_q.push_back(make_tetra('{0,0,0, 0,256,0, 256,0,0, 0,0,256}));
    pending_q.push_back(make_tetra('{-32768,-32768,-32768, 32767,-32768,-32768,
                                     -32768,32767,-32768, -32768,-32768,32767}));
    pending_q.push_back(make_tetra('{32767,32767,32767, -32768,32767,32767,
                                     32767,-32768,32767, 32767,32767,-32768}));
    pending_q.push_back(make_tetra('{-32768,0,32767, 32767,-32768,0,
                                     0,32767,-32768, 100,-200,300}));
    // nearly flat: huge center, saturates
    pending_q.push_back(make_tetra('{0,0,0, 32767,0,0, 0,32767,0, 16000,16000,1}));
    pending_q.push_back(make_tetra('{0,0,0, -32768,0,0, 0,-32768,0, -16000,-16000,-1}));
    // coplanar and collinear
    pending_q.push_back(make_tetra('{0,0,0, 256,0,0, 0,256,0, 256,256,0}));
    pending_q.push_back(make_tetra('{5,5,5, 10,10,10, 15,15,15, 20,20,20}));
    pending_q.push_back(make_tetra('{1,2,3, 4,5,6, 1,2,3, 7,8,9}));
    // small offsets exercise rounding
    pending_q.push_back(make_tetra('{0,0,0, 1,0,0, 0,1,0, 0,0,1}));
    pending_q.push_back(make_tetra('{0,0,0, 3,0,0, 0,3,0, 0,0,3}));
    pending_q.push_back(make_tetra('{-1,-1,-1, 2,-1,-1, -1,2,-1, -1,-1,2}));
    pending_q.push_back(make_tetra('{100,-100,50, -300,200,7, 55,-1,-90, 12,34,-56}));
    for (int i = 0; i < 700; i++) begin
      if (i == 350) begin
        t.hold_for_drain = 1;
        pending_q.push_back(t);
      end
      pending_q.push_back(random_tetra());
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (LAT + 30) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0)
      $display("** tetra_circumcenter_core: PASSED **");
    else
      $display("** tetra_circumcenter_core: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** tetra_circumcenter_core: FAILED **");
    $finish;
  end

endmodule
